@@ hw/rtl/petri_net_firing_engine_unit_macros.svh @@
// Assertion macros used by the firing engine checker.
`ifndef PETRI_NET_FIRING_ENGINE_UNIT_MACROS_SVH
`define PETRI_NET_FIRING_ENGINE_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define PNFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define PNFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/pnfe_pkg.sv @@
// Shared types, register map and reset constants of the firing engine.
package pnfe_pkg;

	// APB register map
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 2;

	typedef logic [IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_PRE_ARCS        = 2'd0;
	localparam reg_idx_t REG_POST_ARCS       = 2'd1;
	localparam reg_idx_t REG_INITIAL_MARKING = 2'd2;
	localparam reg_idx_t REG_PACKET_LIMIT    = 2'd3;

	// Counter of transition zero firings
	localparam int COUNT_W = 16;

	// Result status codes
	typedef logic [1:0] status_t;

	localparam status_t STATUS_FIRED    = 2'd0;
	localparam status_t STATUS_REFUSED  = 2'd1;
	localparam status_t STATUS_OVERFLOW = 2'd2;

	// Register reset values
	localparam logic [DATA_W-1:0]  PRE_ARCS_RESET        = 32'd37241106;
	localparam logic [DATA_W-1:0]  POST_ARCS_RESET       = 32'd79829064;
	localparam logic [DATA_W-1:0]  INITIAL_MARKING_RESET = 32'd1049891;
	localparam logic [COUNT_W-1:0] PACKET_LIMIT_RESET    = 16'd10;

	// Outcome of one firing step
	typedef struct packed {
		status_t status;
		logic    commit;
	} fire_ctl_t;

endpackage

@@ hw/rtl/pnfe_enable.sv @@
// Enabled-transition mask from a marking, the pre-arcs and the limit flag.
module pnfe_enable #(
	parameter int NUM_PLACES      = 7,
	parameter int NUM_TRANSITIONS = 4,
	parameter int TOKEN_BITS      = 4
) (
	input  logic [NUM_PLACES*TOKEN_BITS-1:0]      marking,
	input  logic [NUM_PLACES*NUM_TRANSITIONS-1:0] pre_arcs,
	input  logic                                  at_limit,
	output logic [NUM_TRANSITIONS-1:0]            enabled
);

	// Drop a transition when any of its input places is empty
	always_comb begin
		enabled = '1;
		for (int t = 0; t < NUM_TRANSITIONS; t++) begin
			for (int p = 0; p < NUM_PLACES; p++) begin
				if (pre_arcs[p*NUM_TRANSITIONS+t] &&
				    (marking[p*TOKEN_BITS +: TOKEN_BITS] == '0)) begin
					enabled[t] = 1'b0;
				end
			end
		end
		// Transition zero stops once its firing budget is used up
		if (at_limit) begin
			enabled[0] = 1'b0;
		end
	end

endmodule

@@ hw/rtl/pnfe_fire.sv @@
// Next marking and counter for one set of firing transitions.
module pnfe_fire #(
	parameter int NUM_PLACES      = 7,
	parameter int NUM_TRANSITIONS = 4,
	parameter int TOKEN_BITS      = 4
) (
	input  logic [NUM_PLACES*TOKEN_BITS-1:0]      marking,
	input  logic [NUM_PLACES*NUM_TRANSITIONS-1:0] pre_arcs,
	input  logic [NUM_PLACES*NUM_TRANSITIONS-1:0] post_arcs,
	input  logic [NUM_TRANSITIONS-1:0]            fire,
	input  logic [pnfe_pkg::COUNT_W-1:0]          count,
	output logic [NUM_PLACES*TOKEN_BITS-1:0]      marking_next,
	output logic [pnfe_pkg::COUNT_W-1:0]          count_next,
	output pnfe_pkg::fire_ctl_t                   ctl
);

	import pnfe_pkg::*;

	localparam int CW        = $clog2(NUM_TRANSITIONS + 1);
	localparam int SW        = TOKEN_BITS + CW;
	localparam int TOKEN_MAX = (1 << TOKEN_BITS) - 1;

	logic [NUM_PLACES*TOKEN_BITS-1:0] cand;
	logic                             neg;
	logic                             ovf;

	// Add produced tokens, subtract consumed ones, flag under- and overflow
	always_comb begin
		logic [CW-1:0] gain;
		logic [CW-1:0] loss;
		logic [SW-1:0] sum;
		logic [SW-1:0] diff;
		neg  = 1'b0;
		ovf  = 1'b0;
		cand = '0;
		for (int p = 0; p < NUM_PLACES; p++) begin
			gain = '0;
			loss = '0;
			for (int t = 0; t < NUM_TRANSITIONS; t++) begin
				if (fire[t]) begin
					gain = gain + CW'(post_arcs[p*NUM_TRANSITIONS+t]);
					loss = loss + CW'(pre_arcs[p*NUM_TRANSITIONS+t]);
				end
			end
			sum  = SW'(marking[p*TOKEN_BITS +: TOKEN_BITS]) + SW'(gain);
			diff = '0;
			if (sum < SW'(loss)) begin
				neg = 1'b1;
			end else begin
				diff = sum - SW'(loss);
				if (diff > SW'(TOKEN_MAX)) begin
					ovf = 1'b1;
				end
			end
			cand[p*TOKEN_BITS +: TOKEN_BITS] = diff[TOKEN_BITS-1:0];
		end
	end

	// Decide the outcome; an empty set or a negative place wins over overflow
	always_comb begin
		if ((fire == '0) || neg) begin
			ctl.status = STATUS_REFUSED;
		end else if (ovf) begin
			ctl.status = STATUS_OVERFLOW;
		end else begin
			ctl.status = STATUS_FIRED;
		end
		ctl.commit = (ctl.status == STATUS_FIRED);
	end

	// Keep the old state on a refused or overflowing step
	assign marking_next = ctl.commit ? cand : marking;
	assign count_next   = (ctl.commit && fire[0]) ? count + COUNT_W'(1) : count;

endmodule

@@ hw/rtl/petri_net_firing_engine_unit.sv @@
// Petri net firing engine: takes one request mask of transitions per cycle while not
// stalled and returns one result per request. A request taken at a clock edge sits in the
// input register, is evaluated and lands in the result register once that register is
// free or drains. The marking and the transition zero counter are updated in the same
// cycle the result is computed, so the next request sees them at once and, while
// out_stall stays low, the block sustains one request per clock; the marking update
// loop sets the rate. A result waiting under out_stall holds the request register behind
// it, and a request held there stalls the input. Configuration goes through the APB port;
// the user writes it only while the block is idle, as the block does not enforce this.
module petri_net_firing_engine_unit #(
	parameter int NUM_PLACES      = 7,
	parameter int NUM_TRANSITIONS = 4,
	parameter int TOKEN_BITS      = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pnfe_pkg::ADDR_W-1:0]           paddr,
	input  logic [pnfe_pkg::DATA_W-1:0]           pwdata,
	output logic [pnfe_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [NUM_TRANSITIONS-1:0]            fire_request,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic [NUM_PLACES*TOKEN_BITS-1:0]      marking_now,
	output logic [NUM_TRANSITIONS-1:0]            enabled_mask,
	output logic                                  finished,
	output logic [pnfe_pkg::COUNT_W-1:0]          fired_count
);

	import pnfe_pkg::*;

	localparam int ARC_W  = NUM_PLACES * NUM_TRANSITIONS;
	localparam int MARK_W = NUM_PLACES * TOKEN_BITS;

	// configuration registers
	logic [ARC_W-1:0]   pre_q;
	logic [ARC_W-1:0]   post_q;
	logic [MARK_W-1:0]  init_q;
	logic [COUNT_W-1:0] limit_q;

	// net state
	logic [MARK_W-1:0]  marking_q;
	logic [COUNT_W-1:0] count_q;

	// request register
	logic                       valid_s1;
	logic [NUM_TRANSITIONS-1:0] req_s1;

	// result register
	logic                       valid_s2;
	status_t                    status_s2;
	logic [MARK_W-1:0]          marking_s2;
	logic [NUM_TRANSITIONS-1:0] enabled_s2;
	logic                       finished_s2;
	logic [COUNT_W-1:0]         count_s2;

	logic                       advance;
	logic                       step;
	logic                       cfg_wr;
	reg_idx_t                   cfg_idx;
	logic [NUM_TRANSITIONS-1:0] en_cur;
	logic [NUM_TRANSITIONS-1:0] en_nxt;
	logic [NUM_TRANSITIONS-1:0] fire;
	logic [MARK_W-1:0]          marking_next;
	logic [COUNT_W-1:0]         count_next;
	logic                       at_limit_next;
	fire_ctl_t                  ctl;

	// Handshake: move the request on when the result register is free or drains
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	// Configuration write decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q   <= ARC_W'(PRE_ARCS_RESET);
			post_q  <= ARC_W'(POST_ARCS_RESET);
			init_q  <= MARK_W'(INITIAL_MARKING_RESET);
			limit_q <= PACKET_LIMIT_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PRE_ARCS:        pre_q   <= ARC_W'(pwdata);
				REG_POST_ARCS:       post_q  <= ARC_W'(pwdata);
				REG_INITIAL_MARKING: init_q  <= MARK_W'(pwdata);
				REG_PACKET_LIMIT:    limit_q <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (cfg_idx)
			REG_PRE_ARCS:        prdata = DATA_W'(pre_q);
			REG_POST_ARCS:       prdata = DATA_W'(post_q);
			REG_INITIAL_MARKING: prdata = DATA_W'(init_q);
			REG_PACKET_LIMIT:    prdata = DATA_W'(limit_q);
			default:             prdata = '0;
		endcase
	end

	// Enabled set before the step
	pnfe_enable #(
		.NUM_PLACES      (NUM_PLACES),
		.NUM_TRANSITIONS (NUM_TRANSITIONS),
		.TOKEN_BITS      (TOKEN_BITS)
	) u_en_cur (
		.marking  (marking_q),
		.pre_arcs (pre_q),
		.at_limit (count_q >= limit_q),
		.enabled  (en_cur)
	);

	assign fire = req_s1 & en_cur;

	// Fire the requested and enabled transitions together
	pnfe_fire #(
		.NUM_PLACES      (NUM_PLACES),
		.NUM_TRANSITIONS (NUM_TRANSITIONS),
		.TOKEN_BITS      (TOKEN_BITS)
	) u_fire (
		.marking      (marking_q),
		.pre_arcs     (pre_q),
		.post_arcs    (post_q),
		.fire         (fire),
		.count        (count_q),
		.marking_next (marking_next),
		.count_next   (count_next),
		.ctl          (ctl)
	);

	assign at_limit_next = (count_next >= limit_q);

	// Enabled set after the step
	pnfe_enable #(
		.NUM_PLACES      (NUM_PLACES),
		.NUM_TRANSITIONS (NUM_TRANSITIONS),
		.TOKEN_BITS      (TOKEN_BITS)
	) u_en_nxt (
		.marking  (marking_next),
		.pre_arcs (pre_q),
		.at_limit (at_limit_next),
		.enabled  (en_nxt)
	);

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= fire_request;
		end
	end

	// Net state: commit the step as the result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marking_q <= MARK_W'(INITIAL_MARKING_RESET);
			count_q   <= '0;
		end else if (step) begin
			marking_q <= marking_next;
			count_q   <= count_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_s2   <= ctl.status;
			marking_s2  <= marking_next;
			enabled_s2  <= en_nxt;
			finished_s2 <= (marking_next == init_q) && at_limit_next;
			count_s2    <= count_next;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = status_s2;
	assign marking_now  = marking_s2;
	assign enabled_mask = enabled_s2;
	assign finished     = finished_s2;
	assign fired_count  = count_s2;

endmodule

@@ hw/rtl/pnfe_checker.sv @@
// Port-level checker of the firing engine and its bind to the top level.
`include "petri_net_firing_engine_unit_macros.svh"

module pnfe_checker #(
	parameter int NUM_PLACES      = 7,
	parameter int NUM_TRANSITIONS = 4,
	parameter int TOKEN_BITS      = 4
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [1:0]                            status,
	input logic [NUM_PLACES*TOKEN_BITS-1:0]      marking_now,
	input logic [NUM_TRANSITIONS-1:0]            enabled_mask,
	input logic [pnfe_pkg::COUNT_W-1:0]          fired_count
);

	import pnfe_pkg::*;

	logic                              out_acc;
	logic                              have_prev_q;
	logic [NUM_PLACES*TOKEN_BITS-1:0]  prev_marking_q;
	logic [COUNT_W-1:0]                prev_count_q;

	assign out_acc = out_valid && !out_stall;

	// Track the state reported by the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q    <= 1'b0;
			prev_marking_q <= '0;
			prev_count_q   <= '0;
		end else if (out_acc) begin
			have_prev_q    <= 1'b1;
			prev_marking_q <= marking_now;
			prev_count_q   <= fired_count;
		end
	end

	// A stalled result holds
	`PNFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(marking_now) && $stable(enabled_mask) && $stable(fired_count), "stalled result changed")

	// A refused or overflowing request leaves marking and counter as the previous result showed
	`PNFE_ASSERT_NOW(a_refused_keeps, out_acc && have_prev_q && (status != STATUS_FIRED), (marking_now == prev_marking_q) && (fired_count == prev_count_q), "refused request changed state")

	// The counter advances by at most one per request
	`PNFE_ASSERT_NOW(a_count_step, out_acc && have_prev_q, (fired_count == prev_count_q) || (fired_count == prev_count_q + COUNT_W'(1)), "counter jumped")

endmodule

bind petri_net_firing_engine_unit pnfe_checker #(
	.NUM_PLACES      (NUM_PLACES),
	.NUM_TRANSITIONS (NUM_TRANSITIONS),
	.TOKEN_BITS      (TOKEN_BITS)
) u_pnfe_checker (.*);

@@ test/petri_net_firing_engine_unit_tb.sv @@
// Self-checking regression of the Petri net firing engine, with a scoreboard that predicts each result.
module petri_net_firing_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pnfe_pkg::*;

	localparam int PLACES = 7;
	localparam int TRANS = 4;
	localparam int TOK_W = 4;
	localparam int MARK_W = PLACES * TOK_W;
	localparam int RUN_LIMIT = 120000;
	localparam int LONG_HOLD = 300;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 95;

	typedef struct packed {
		status_t             status;
		logic [MARK_W-1:0]   marking;
		logic [TRANS-1:0]    enabled;
		logic                finished;
		logic [COUNT_W-1:0]  count;
	} firing_result_t;

	// Marking predictor and queue of pending firing results
	class firing_scoreboard;
		logic [MARK_W-1:0]  pre_arcs;
		logic [MARK_W-1:0]  post_arcs;
		logic [MARK_W-1:0]  init_marking;
		logic [COUNT_W-1:0] limit;
		logic [TOK_W-1:0]   tokens[PLACES];
		logic [COUNT_W-1:0] t0_firings;
		firing_result_t     expected_q[$];
		int                 failures;
		int                 reported;

		function new();
			pre_arcs = PRE_ARCS_RESET[MARK_W-1:0];
			post_arcs = POST_ARCS_RESET[MARK_W-1:0];
			init_marking = INITIAL_MARKING_RESET[MARK_W-1:0];
			limit = PACKET_LIMIT_RESET;
			for (int p = 0; p < PLACES; p++)
				tokens[p] = init_marking[p*TOK_W +: TOK_W];
			t0_firings = '0;
			failures = 0;
			reported = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_PRE_ARCS:        pre_arcs = data[MARK_W-1:0];
				REG_POST_ARCS:       post_arcs = data[MARK_W-1:0];
				REG_INITIAL_MARKING: init_marking = data[MARK_W-1:0];
				REG_PACKET_LIMIT:    limit = data[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		// Transitions whose input places all hold a token, transition zero gated by its limit
		function logic [TRANS-1:0] enabled_set();
			logic [TRANS-1:0] mask;
			mask = '1;
			for (int t = 0; t < TRANS; t++)
				for (int p = 0; p < PLACES; p++)
					if (pre_arcs[p*TRANS+t] && tokens[p] == 0)
						mask[t] = 1'b0;
			if (t0_firings >= limit)
				mask[0] = 1'b0;
			return mask;
		endfunction

		function logic [MARK_W-1:0] packed_marking();
			logic [MARK_W-1:0] m;
			for (int p = 0; p < PLACES; p++)
				m[p*TOK_W +: TOK_W] = tokens[p];
			return m;
		endfunction

		// Fire the enabled part of a request and queue the result it produces
		function void note_request(logic [TRANS-1:0] req);
			logic [TRANS-1:0] fire;
			int               nxt[PLACES];
			int               gain;
			int               loss;
			bit               negative;
			bit               overflow;
			firing_result_t   r;
			fire = req & enabled_set();
			negative = 0;
			overflow = 0;
			r.status = STATUS_FIRED;
			if (fire == 0) begin
				r.status = STATUS_REFUSED;
			end else begin
				for (int p = 0; p < PLACES; p++) begin
					gain = 0;
					loss = 0;
					for (int t = 0; t < TRANS; t++)
						if (fire[t]) begin
							gain += post_arcs[p*TRANS+t];
							loss += pre_arcs[p*TRANS+t];
						end
					nxt[p] = int'(tokens[p]) + gain - loss;
					if (nxt[p] < 0)
						negative = 1;
					else if (nxt[p] > (1 << TOK_W) - 1)
						overflow = 1;
				end
				// negative beats overflow; a refused or overflowing step leaves the state alone
				if (negative) begin
					r.status = STATUS_REFUSED;
				end else if (overflow) begin
					r.status = STATUS_OVERFLOW;
				end else begin
					for (int p = 0; p < PLACES; p++)
						tokens[p] = nxt[p][TOK_W-1:0];
					if (fire[0])
						t0_firings = t0_firings + 1'b1;
				end
			end
			r.marking = packed_marking();
			r.enabled = enabled_set();
			r.finished = (packed_marking() == init_marking) && (t0_firings >= limit);
			r.count = t0_firings;
			expected_q.push_back(r);
		endfunction

		function void check_result(firing_result_t got);
			firing_result_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result: status %0d marking %h", got.status, got.marking);
				end
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("mismatch exp/got: status %0d/%0d marking %h/%h enabled %h/%h finished %0b/%0b count %0d/%0d",
						want.status, got.status, want.marking, got.marking, want.enabled,
						got.enabled, want.finished, got.finished, want.count, got.count);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [TRANS-1:0]     fire_request = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           status;
	logic [MARK_W-1:0]    marking_now;
	logic [TRANS-1:0]     enabled_mask;
	logic                 finished;
	logic [COUNT_W-1:0]   fired_count;

	firing_scoreboard sb = new();
	bit  no_gaps = 0;
	bit  hold_long = 0;
	int  cycle_count = 0;

	petri_net_firing_engine_unit #(
		.NUM_PLACES(PLACES),
		.NUM_TRANSITIONS(TRANS),
		.TOKEN_BITS(TOK_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.fire_request(fire_request),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.marking_now(marking_now),
		.enabled_mask(enabled_mask),
		.finished(finished),
		.fired_count(fired_count)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(firing_result_t'({status, marking_now, enabled_mask, finished,
				fired_count}));
	end

	// Stall the result side at random, with one long hold-off on request
	initial begin : result_sink
		int n;
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_long = 0;
			end else begin
				n = no_gaps ? 0 : $urandom_range(0, 5);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [MARK_W-1:0] pre_mask, logic [MARK_W-1:0] post_mask,
			logic [MARK_W-1:0] init_mask, logic [COUNT_W-1:0] lim);
		// random upper bits must be dropped by the block
		apb_write(REG_PRE_ARCS, {4'($urandom_range(0, 15)), pre_mask});
		apb_write(REG_POST_ARCS, {4'($urandom_range(0, 15)), post_mask});
		apb_write(REG_INITIAL_MARKING, {4'($urandom_range(0, 15)), init_mask});
		apb_write(REG_PACKET_LIMIT, {16'($urandom), lim});
	endtask

	// Offer one request after a random gap and wait for it to be taken
	task automatic send(logic [TRANS-1:0] req);
		int n;
		n = no_gaps ? 0 : $urandom_range(0, 5);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		fire_request <= req;
		do @(posedge clk); while (in_stall);
		sb.note_request(req);
	endtask

	// Drop valid and wait until every pending result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [MARK_W-1:0] sparse_bits(int odds);
		logic [MARK_W-1:0] v;
		for (int b = 0; b < MARK_W; b++)
			v[b] = ($urandom_range(0, odds - 1) == 0);
		return v;
	endfunction

	initial begin
		logic [MARK_W-1:0]  pre_mask;
		logic [MARK_W-1:0]  post_mask;
		logic [MARK_W-1:0]  init_mask;
		logic [COUNT_W-1:0] lim;
		int                 src;
		int                 dst;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pump place three with every transition
		apb_write(REG_PRE_ARCS, '0);
		apb_write(REG_POST_ARCS, 32'h0000_F000);
		repeat (3) send(4'b1111);
		drain_results();

		// drain place zero: too deep while place three overflows, then exact, then empty
		apb_write(REG_PRE_ARCS, 32'h0000_000F);
		send(4'b1111);
		send(4'b0111);
		send(4'b1111);
		drain_results();

		// overflow alone, then an empty request
		apb_write(REG_PRE_ARCS, '0);
		send(4'b1111);
		send(4'b0000);
		drain_results();

		// limit lowered below the count, marking taken as initial
		apb_write(REG_INITIAL_MARKING, DATA_W'(sb.packed_marking()));
		apb_write(REG_PACKET_LIMIT, 32'd1);
		send(4'b0000);
		send(4'b0001);
		drain_results();

		// every request mask on the default net with transition zero blocked
		configure(PRE_ARCS_RESET[MARK_W-1:0], POST_ARCS_RESET[MARK_W-1:0],
			INITIAL_MARKING_RESET[MARK_W-1:0], '0);
		for (int r = 0; r < 16; r++)
			send(TRANS'(r));
		drain_results();

		// random phases, each on a fresh net
		for (int ph = 0; ph < PHASES; ph++) begin
			no_gaps = (ph % 3 == 1);
			case (ph)
				0: begin
					pre_mask = PRE_ARCS_RESET[MARK_W-1:0];
					post_mask = POST_ARCS_RESET[MARK_W-1:0];
					init_mask = INITIAL_MARKING_RESET[MARK_W-1:0];
					lim = '1;
				end
				1: begin
					pre_mask = '0;
					post_mask = '0;
					init_mask = '0;
					lim = 16'($urandom);
				end
				2: begin
					pre_mask = '1;
					post_mask = '1;
					init_mask = '1;
					lim = '0;
				end
				default: begin
					if ($urandom_range(0, 9) < 7) begin
						// each transition moves a token from one place to another
						pre_mask = '0;
						post_mask = '0;
						for (int t = 0; t < TRANS; t++) begin
							src = $urandom_range(0, PLACES - 1);
							dst = $urandom_range(0, PLACES - 1);
							pre_mask[src*TRANS+t] = 1'b1;
							post_mask[dst*TRANS+t] = 1'b1;
						end
					end else begin
						pre_mask = sparse_bits($urandom_range(3, 6));
						post_mask = sparse_bits($urandom_range(3, 6));
					end
					init_mask = $urandom_range(0, 1) ? sb.packed_marking() : MARK_W'($urandom);
					case ($urandom_range(0, 3))
						0: lim = sb.t0_firings;
						1: lim = sb.t0_firings + COUNT_W'($urandom_range(1, 30));
						2: lim = COUNT_W'($urandom_range(0, sb.t0_firings));
						default: lim = '1;
					endcase
				end
			endcase
			configure(pre_mask, post_mask, init_mask, lim);
			if (ph == 3)
				hold_long = 1;
			repeat (PHASE_ITEMS) send(TRANS'($urandom_range(0, 15)));
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
